### sv/wbb_pkg.sv
// Shared constants and types for the white blob bounding box block.
// No dependencies; the front end, scanner and top level refer to it by scoped names.
package wbb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_BOXES_DEF  = 25;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_W       = 11;
    localparam int PIXEL_W     = 8;
    localparam int COORD_OUT_W = 10;
    localparam int COUNT_OUT_W = 5;

    localparam logic [PIXEL_W-1:0] WHITE_VALUE  = 8'hFF;
    localparam logic [CFG_W-1:0]   WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0]   HEIGHT_RESET = 11'd480;

    // Configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PX_RD,
        S_PX_CHK,
        S_IN,
        S_G_RD,
        S_G_CHK,
        S_L_RD,
        S_L_CHK,
        S_R_RD,
        S_R_CHK,
        S_B_RD,
        S_B_CHK,
        S_EMIT
    } scan_state_t;

endpackage

### sv/wbb_front.sv
// Front end: accepts pixels, classifies them as white and tags the frame end.
// Depends on wbb_pkg; feeds wbb_queue.
module wbb_front #(
    parameter int DIM_W  = 11,
    parameter int ADDR_W = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [wbb_pkg::PIXEL_W-1:0] pixel,
    input  logic [DIM_W-1:0]           cur_w,
    input  logic [DIM_W-1:0]           cur_h,
    input  logic                       q_full,
    output logic                       q_push,
    output logic [ADDR_W+1:0]          q_data
);

    localparam int TOT_W = 2 * DIM_W;

    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic [ADDR_W:0]   pos_inc;
    logic [TOT_W-1:0]  total;
    logic              last;
    logic              white;

    // Classify the pixel and detect the frame end
    always_comb
    begin
        total   = TOT_W'(cur_w) * TOT_W'(cur_h);
        pos_inc = {1'b0, pos_reg} + (ADDR_W+1)'(1);
        last    = TOT_W'(pos_inc) >= total;
        white   = (pixel == wbb_pkg::WHITE_VALUE);
        q_push  = push && !q_full;
        q_data  = {last, white, pos_reg};
        pos_next = pos_reg;
        if (q_push)
        begin
            pos_next = last ? '0 : pos_inc[ADDR_W-1:0];
        end
    end

    // Advance the load position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

### sv/wbb_queue.sv
// Short queue between the front end and the scanner.
// Does not depend on wbb_pkg; generic width and depth.
module wbb_queue #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

### sv/wbb_scan.sv
// Back end: owns the white mask memory and the box store, scans the frame
// and presents boxes through an output register. Depends on wbb_pkg.
module wbb_scan #(
    parameter int DIM_W     = 11,
    parameter int ADDR_W    = 20,
    parameter int MAX_BOXES = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [DIM_W-1:0]               cur_w,
    input  logic [DIM_W-1:0]               cur_h,
    input  logic                           q_empty,
    input  logic [ADDR_W+1:0]              q_data,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [wbb_pkg::COORD_OUT_W-1:0] box_top,
    output logic [wbb_pkg::COORD_OUT_W-1:0] box_bottom,
    output logic [wbb_pkg::COORD_OUT_W-1:0] box_left,
    output logic [wbb_pkg::COORD_OUT_W-1:0] box_right,
    output logic [wbb_pkg::COUNT_OUT_W-1:0] box_index,
    output logic [wbb_pkg::COUNT_OUT_W-1:0] object_count,
    output logic                           box_valid,
    output logic                           overflow,
    output logic                           final_res
);

    localparam int MASK_DEPTH = 1 << ADDR_W;
    localparam int BOXC_W     = $clog2(MAX_BOXES + 1);
    localparam int BIDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int CO_W       = wbb_pkg::COORD_OUT_W;
    localparam int CN_W       = wbb_pkg::COUNT_OUT_W;

    wbb_pkg::scan_state_t state_reg, state_next;

    logic                mask_mem [MASK_DEPTH];
    logic                mask_q;
    logic [ADDR_W-1:0]   rd_addr;
    logic [DIM_W-1:0]    rd_row;
    logic [DIM_W-1:0]    rd_col;
    logic [PROD_W-1:0]   rd_prod;

    logic [DIM_W-1:0] top_mem [MAX_BOXES];
    logic [DIM_W-1:0] bot_mem [MAX_BOXES];
    logic [DIM_W-1:0] lft_mem [MAX_BOXES];
    logic [DIM_W-1:0] rgt_mem [MAX_BOXES];
    logic             store_en;
    logic [DIM_W-1:0] store_bot;

    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] gr_reg, gr_next;
    logic [DIM_W-1:0] lo_reg, lo_next;
    logic [DIM_W-1:0] hi_reg, hi_next;
    logic [DIM_W-1:0] lft_reg, lft_next;
    logic [DIM_W-1:0] rgt_reg, rgt_next;
    logic [DIM_W-1:0] runa_reg, runa_next;
    logic [DIM_W-1:0] runb_reg, runb_next;
    logic [DIM_W-1:0] x_reg, x_next;
    logic [DIM_W-1:0] y_reg, y_next;
    logic [DIM_W-1:0] bot_reg, bot_next;
    logic [DIM_W-1:0] last_reg, last_next;
    logic [BIDX_W-1:0] bx_reg, bx_next;
    logic [BOXC_W-1:0] total_reg, total_next;
    logic              ovf_reg, ovf_next;

    logic            out_vld_reg, out_vld_next;
    logic [CO_W-1:0] o_top_reg, o_bot_reg, o_lft_reg, o_rgt_reg;
    logic [CN_W-1:0] o_idx_reg, o_cnt_reg;
    logic            o_bvld_reg, o_ovf_reg, o_fin_reg;
    logic            out_load;
    logic            out_zero;

    logic do_next_col, do_next_row, do_viable, do_end_walk, do_col_done, do_finish;
    logic in_box;
    logic slot_free;
    logic emit_last;
    logic [DIM_W-1:0] col_bot;

    logic [ADDR_W-1:0] q_addr;
    logic              q_white;
    logic              q_last;

    assign q_addr  = q_data[ADDR_W-1:0];
    assign q_white = q_data[ADDR_W];
    assign q_last  = q_data[ADDR_W+1];

    // Mask memory: one write port from the queue, one registered read port
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mask_mem[q_addr] <= q_white;
        end
        mask_q <= mask_mem[rd_addr];
    end

    // Select the read coordinate for the walk in progress
    always_comb
    begin
        rd_row = row_reg;
        rd_col = col_reg;
        unique case (state_reg)
            wbb_pkg::S_G_RD:
            begin
                rd_row = gr_reg;
            end
            wbb_pkg::S_L_RD:
            begin
                rd_row = gr_reg;
                rd_col = lo_reg - DIM_W'(1);
            end
            wbb_pkg::S_R_RD:
            begin
                rd_row = gr_reg;
                rd_col = hi_reg + DIM_W'(1);
            end
            wbb_pkg::S_B_RD:
            begin
                rd_row = y_reg + DIM_W'(1);
                rd_col = x_reg;
            end
            default:
            begin
                rd_row = row_reg;
                rd_col = col_reg;
            end
        endcase
        rd_prod = PROD_W'(rd_row) * PROD_W'(cur_w) + PROD_W'(rd_col);
        rd_addr = rd_prod[ADDR_W-1:0];
    end

    // Box test against the entry under bx
    assign in_box = (row_reg >= top_mem[bx_reg]) && (row_reg <= bot_mem[bx_reg]) &&
                    (col_reg >= lft_mem[bx_reg]) && (col_reg <= rgt_mem[bx_reg]);
    assign col_bot   = (y_reg > bot_reg) ? y_reg : bot_reg;
    assign slot_free = !out_vld_reg || pop;
    assign emit_last = (BOXC_W'(bx_reg) + BOXC_W'(1)) == total_reg;

    // Next state and scan datapath
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        gr_next    = gr_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        lft_next   = lft_reg;
        rgt_next   = rgt_reg;
        runa_next  = runa_reg;
        runb_next  = runb_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        bot_next   = bot_reg;
        last_next  = last_reg;
        bx_next    = bx_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        q_pop      = 1'b0;
        store_en   = 1'b0;
        store_bot  = col_bot;
        out_load   = 1'b0;
        out_zero   = 1'b0;
        do_next_col = 1'b0;
        do_next_row = 1'b0;
        do_viable   = 1'b0;
        do_end_walk = 1'b0;
        do_col_done = 1'b0;
        do_finish   = 1'b0;

        unique case (state_reg)
            wbb_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_last)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        total_next = '0;
                        ovf_next   = 1'b0;
                        state_next = wbb_pkg::S_PX_RD;
                    end
                end
            end
            wbb_pkg::S_PX_RD:
            begin
                state_next = wbb_pkg::S_PX_CHK;
            end
            wbb_pkg::S_PX_CHK:
            begin
                if (!mask_q)
                begin
                    do_next_col = 1'b1;
                end
                else if (total_reg == '0)
                begin
                    do_viable = 1'b1;
                end
                else
                begin
                    bx_next    = '0;
                    state_next = wbb_pkg::S_IN;
                end
            end
            wbb_pkg::S_IN:
            begin
                if (in_box)
                begin
                    do_next_col = 1'b1;
                end
                else if ((BOXC_W'(bx_reg) + BOXC_W'(1)) < total_reg)
                begin
                    bx_next = bx_reg + BIDX_W'(1);
                end
                else
                begin
                    do_viable = 1'b1;
                end
            end
            wbb_pkg::S_G_RD:
            begin
                if (gr_reg >= cur_h)
                begin
                    do_end_walk = 1'b1;
                end
                else
                begin
                    state_next = wbb_pkg::S_G_CHK;
                end
            end
            wbb_pkg::S_G_CHK:
            begin
                if (mask_q)
                begin
                    lo_next    = col_reg;
                    hi_next    = col_reg;
                    state_next = wbb_pkg::S_L_RD;
                end
                else
                begin
                    do_end_walk = 1'b1;
                end
            end
            wbb_pkg::S_L_RD:
            begin
                state_next = (lo_reg == '0) ? wbb_pkg::S_R_RD : wbb_pkg::S_L_CHK;
            end
            wbb_pkg::S_L_CHK:
            begin
                if (mask_q)
                begin
                    lo_next    = lo_reg - DIM_W'(1);
                    state_next = wbb_pkg::S_L_RD;
                end
                else
                begin
                    state_next = wbb_pkg::S_R_RD;
                end
            end
            wbb_pkg::S_R_RD:
            begin
                if ((hi_reg + DIM_W'(1)) >= cur_w)
                begin
                    do_finish = 1'b1;
                end
                else
                begin
                    state_next = wbb_pkg::S_R_CHK;
                end
            end
            wbb_pkg::S_R_CHK:
            begin
                if (mask_q)
                begin
                    hi_next    = hi_reg + DIM_W'(1);
                    state_next = wbb_pkg::S_R_RD;
                end
                else
                begin
                    do_finish = 1'b1;
                end
            end
            wbb_pkg::S_B_RD:
            begin
                if ((y_reg + DIM_W'(1)) >= cur_h)
                begin
                    do_col_done = 1'b1;
                end
                else
                begin
                    state_next = wbb_pkg::S_B_CHK;
                end
            end
            wbb_pkg::S_B_CHK:
            begin
                if (mask_q)
                begin
                    y_next     = y_reg + DIM_W'(1);
                    state_next = wbb_pkg::S_B_RD;
                end
                else
                begin
                    do_col_done = 1'b1;
                end
            end
            wbb_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (total_reg == '0)
                    begin
                        out_zero   = 1'b1;
                        state_next = wbb_pkg::S_IDLE;
                    end
                    else if (emit_last)
                    begin
                        state_next = wbb_pkg::S_IDLE;
                    end
                    else
                    begin
                        bx_next = bx_reg + BIDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = wbb_pkg::S_IDLE;
            end
        endcase

        // Close one row run: widen the box and step down the start column
        if (do_finish)
        begin
            lft_next   = (lo_reg < lft_reg) ? lo_reg : lft_reg;
            rgt_next   = (hi_reg > rgt_reg) ? hi_reg : rgt_reg;
            runa_next  = lo_reg;
            runb_next  = hi_reg;
            gr_next    = gr_reg + DIM_W'(1);
            state_next = wbb_pkg::S_G_RD;
        end

        // Column run ended: start the bottom search over the last row run
        if (do_end_walk)
        begin
            last_next  = gr_reg - DIM_W'(1);
            y_next     = gr_reg - DIM_W'(1);
            bot_next   = gr_reg - DIM_W'(1);
            x_next     = runa_reg;
            state_next = wbb_pkg::S_B_RD;
        end

        // One column of the bottom search done
        if (do_col_done)
        begin
            bot_next = col_bot;
            if (x_reg == runb_reg)
            begin
                store_en    = 1'b1;
                total_next  = total_reg + BOXC_W'(1);
                do_next_row = 1'b1;
            end
            else
            begin
                x_next     = x_reg + DIM_W'(1);
                y_next     = last_reg;
                state_next = wbb_pkg::S_B_RD;
            end
        end

        // New start pixel: open a box or flag overflow
        if (do_viable)
        begin
            if (total_reg == BOXC_W'(MAX_BOXES))
            begin
                ovf_next   = 1'b1;
                bx_next    = '0;
                state_next = wbb_pkg::S_EMIT;
            end
            else
            begin
                lft_next   = col_reg;
                rgt_next   = col_reg;
                gr_next    = row_reg;
                state_next = wbb_pkg::S_G_RD;
            end
        end

        // Advance along the row
        if (do_next_col)
        begin
            if ((col_reg + DIM_W'(1)) < cur_w)
            begin
                col_next   = col_reg + DIM_W'(1);
                state_next = wbb_pkg::S_PX_RD;
            end
            else
            begin
                do_next_row = 1'b1;
            end
        end

        // Advance to the next row or to emission
        if (do_next_row)
        begin
            if ((row_reg + DIM_W'(1)) < cur_h)
            begin
                row_next   = row_reg + DIM_W'(1);
                col_next   = '0;
                state_next = wbb_pkg::S_PX_RD;
            end
            else
            begin
                bx_next    = '0;
                state_next = wbb_pkg::S_EMIT;
            end
        end

        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Box store
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            top_mem[total_reg[BIDX_W-1:0]] <= row_reg;
            bot_mem[total_reg[BIDX_W-1:0]] <= store_bot;
            lft_mem[total_reg[BIDX_W-1:0]] <= lft_reg;
            rgt_mem[total_reg[BIDX_W-1:0]] <= rgt_reg;
        end
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        gr_reg   <= gr_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        lft_reg  <= lft_next;
        rgt_reg  <= rgt_next;
        runa_reg <= runa_next;
        runb_reg <= runb_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        bot_reg  <= bot_next;
        last_reg <= last_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        bx_reg   <= bx_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wbb_pkg::S_IDLE;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Output register: load one result transaction
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (out_zero)
            begin
                o_top_reg  <= '0;
                o_bot_reg  <= '0;
                o_lft_reg  <= '0;
                o_rgt_reg  <= '0;
                o_idx_reg  <= '0;
                o_cnt_reg  <= '0;
                o_bvld_reg <= 1'b0;
                o_ovf_reg  <= 1'b0;
                o_fin_reg  <= 1'b1;
            end
            else
            begin
                o_top_reg  <= CO_W'(top_mem[bx_reg]);
                o_bot_reg  <= CO_W'(bot_mem[bx_reg]);
                o_lft_reg  <= CO_W'(lft_mem[bx_reg]);
                o_rgt_reg  <= CO_W'(rgt_mem[bx_reg]);
                o_idx_reg  <= CN_W'(bx_reg);
                o_cnt_reg  <= CN_W'(total_reg);
                o_bvld_reg <= 1'b1;
                o_ovf_reg  <= ovf_reg;
                o_fin_reg  <= emit_last;
            end
        end
    end

    assign empty        = !out_vld_reg;
    assign box_top      = o_top_reg;
    assign box_bottom   = o_bot_reg;
    assign box_left     = o_lft_reg;
    assign box_right    = o_rgt_reg;
    assign box_index    = o_idx_reg;
    assign object_count = o_cnt_reg;
    assign box_valid    = o_bvld_reg;
    assign overflow     = o_ovf_reg;
    assign final_res    = o_fin_reg;

endmodule

### sv/white_blob_bounding_boxes.sv
// Pixels pass through the queue into the mask, one per cycle while the scanner is idle.
// After the last pixel the scan reads and checks each pixel visited, tests stored boxes
// for containment and reads mask pixels in the column, row and bottom walks (one read port).
// Input stalls once the four-entry queue fills while a scan or emission is running.
// Results follow at one per cycle while pop is held, through a single output register.
// Reset: control state clears, frame size returns to 640 x 480; the mask holds no reset value.
module white_blob_bounding_boxes #(
    parameter int MAX_WIDTH  = wbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wbb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_BOXES  = wbb_pkg::MAX_BOXES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [wbb_pkg::PIXEL_W-1:0]     pixel,
    output logic                            empty,
    input  logic                            pop,
    output logic [wbb_pkg::COORD_OUT_W-1:0] box_top,
    output logic [wbb_pkg::COORD_OUT_W-1:0] box_bottom,
    output logic [wbb_pkg::COORD_OUT_W-1:0] box_left,
    output logic [wbb_pkg::COORD_OUT_W-1:0] box_right,
    output logic [wbb_pkg::COUNT_OUT_W-1:0] box_index,
    output logic [wbb_pkg::COUNT_OUT_W-1:0] object_count,
    output logic                            box_valid,
    output logic                            overflow,
    output logic                            final_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [wbb_pkg::CFG_W-1:0]       cfg_data
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int ADDR_W  = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
    localparam int Q_W     = ADDR_W + 2;

    logic [wbb_pkg::CFG_W-1:0] width_reg;
    logic [wbb_pkg::CFG_W-1:0] height_reg;
    logic [DIM_W-1:0]          cur_w;
    logic [DIM_W-1:0]          cur_h;

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    logic [Q_W-1:0] q_wdata;
    logic [Q_W-1:0] q_rdata;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= wbb_pkg::WIDTH_RESET;
            height_reg <= wbb_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                wbb_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                wbb_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // Clamp frame size to 1 .. maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            cur_w = DIM_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            cur_w = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            cur_w = DIM_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            cur_h = DIM_W'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            cur_h = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            cur_h = DIM_W'(height_reg);
        end
    end

    wbb_front #(
        .DIM_W  (DIM_W),
        .ADDR_W (ADDR_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pixel  (pixel),
        .cur_w  (cur_w),
        .cur_h  (cur_h),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    wbb_queue #(
        .WIDTH (Q_W),
        .DEPTH (wbb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    wbb_scan #(
        .DIM_W     (DIM_W),
        .ADDR_W    (ADDR_W),
        .MAX_BOXES (MAX_BOXES)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cur_w        (cur_w),
        .cur_h        (cur_h),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .box_top      (box_top),
        .box_bottom   (box_bottom),
        .box_left     (box_left),
        .box_right    (box_right),
        .box_index    (box_index),
        .object_count (object_count),
        .box_valid    (box_valid),
        .overflow     (overflow),
        .final_res    (final_res)
    );

endmodule
